// File: hw/rtl/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg: shared types and constants for the weighted round-robin scheduler
// Mode codes, controller states and the control/status bundles of the cells.
// ----------------------------------------------------------------------------
package wrr_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_TERM   = 2'd2;

  localparam int PRIO_W = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Broadcast command to every cell of the row
  typedef struct packed {
    logic              create;    // fill the cell at the fill pointer
    logic              kill;      // clear active on the current cell
    logic              dec;       // spend one slice of the current cell
    logic              reload;    // reload slices of the current cell
    logic              tok_start; // launch search token after the current cell
    logic              tok_step;  // move search token one cell on
    logic [PRIO_W-1:0] prio;      // clamped priority for a create
  } cell_ctrl_t;

  // Ring signals handed from one cell to the next
  typedef struct packed {
    logic sel;  // cell is the current slot
    logic tok;  // cell holds the search token
  } ring_t;

  // Cell status seen by the controller
  typedef struct packed {
    logic sel;
    logic zero; // no slices left
    logic hit;  // token sits on an active cell
  } cell_stat_t;

endpackage

// File: hw/rtl/wrr_in_if.sv
// ----------------------------------------------------------------------------
// wrr_in_if: request channel of the scheduler
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface wrr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] priority_req;
  logic       system_busy;

  modport source (output valid, output mode, output priority_req, output system_busy,
                  input ready);
  modport sink   (input valid, input mode, input priority_req, input system_busy,
                  output ready);
endinterface

// File: hw/rtl/wrr_out_if.sv
// ----------------------------------------------------------------------------
// wrr_out_if: status channel of the scheduler
// Valid/ready channel carrying one status beat per request.
// ----------------------------------------------------------------------------
interface wrr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] current_slot;
  logic       running;
  logic       halted;
  logic       rejected;

  modport source (output valid, output current_slot, output running, output halted,
                  output rejected, input ready);
  modport sink   (input valid, input current_slot, input running, input halted,
                  input rejected, output ready);
endinterface

// File: hw/rtl/wrr_cell.sv
// ----------------------------------------------------------------------------
// wrr_cell: one process slot of the scheduler row
// Holds priority, remaining slices and the active flag of one slot, and
// passes the search token on to its neighbour.
// ----------------------------------------------------------------------------
module wrr_cell
  import wrr_pkg::*;
#(
  parameter int IDX = 0,
  parameter int IW  = 3,
  parameter int CW  = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [CW-1:0] cnt_i,
  input  logic [IW-1:0] cur_i,
  input  ring_t      prev_i,
  output ring_t      ring_o,
  output cell_stat_t stat_o
);

  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [PRIO_W-1:0] slices_q, slices_d;
  logic              active_q, active_d;
  logic              tok_q, tok_d;
  logic              sel, wr;

  assign sel = (cur_i == IW'(IDX));
  assign wr  = ctrl_i.create && (cnt_i == CW'(IDX));

  // slot state update
  always_comb begin
    prio_d   = prio_q;
    slices_d = slices_q;
    active_d = active_q;
    if (wr) begin
      prio_d   = ctrl_i.prio;
      slices_d = ctrl_i.prio;
      active_d = 1'b1;
    end else if (sel) begin
      if (ctrl_i.dec)    slices_d = slices_q - 1'b1;
      if (ctrl_i.reload) slices_d = prio_q;
      if (ctrl_i.kill)   active_d = 1'b0;
    end
  end

  // search token: launched after the current cell, then hops one cell a cycle
  always_comb begin
    if (ctrl_i.tok_start) begin
      tok_d = prev_i.sel;
    end else if (ctrl_i.tok_step) begin
      tok_d = prev_i.tok;
    end else begin
      tok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q   <= '0;
      slices_q <= '0;
      active_q <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      prio_q   <= prio_d;
      slices_q <= slices_d;
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  assign ring_o.sel  = sel;
  assign ring_o.tok  = tok_q;
  assign stat_o.sel  = sel;
  assign stat_o.zero = (slices_q == '0);
  assign stat_o.hit  = tok_q && active_q;

endmodule

// File: hw/rtl/weighted_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler: slot scheduler with per-slot slice counts
// Row of slot cells with a controller that decodes requests and runs the
// search for the next active slot.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives one status beat. For a create, a
// terminate, or a tick that only spends a slice (or is ignored), the controller
// passes from idle to the response state, which loads the status beat into the
// output register, and then returns to idle to take the next request. A tick
// that hands over control launches a search token that hops one cell per cycle
// along the slot row in the scan state, and the controller moves on to the
// response state once the token meets an active slot at ring distance k (1 to
// the number of created slots), or once k reaches the number of created slots
// when none is left. The next request is taken once the status beat is in the
// output register. The status beat waits in that register until taken, and a
// further status beat waits in the controller until the register is free.
module weighted_round_robin_scheduler
  import wrr_pkg::*;
#(
  parameter int MAX_PROCS    = 8,
  parameter int MAX_PRIORITY = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  wrr_in_if.sink    in_i,
  wrr_out_if.source out_o
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic [IW-1:0] cur_q, cur_d;
  logic          started_q, started_d;
  logic          halted_q, halted_d;
  logic          rej_q, rej_d;

  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_cur_q;
  logic          out_run_q, out_halt_q, out_rej_q;
  logic          out_load;

  cell_ctrl_t    ctrl;
  ring_t         ring   [MAX_PROCS];
  ring_t         prev   [MAX_PROCS];
  cell_stat_t    stat   [MAX_PROCS];
  logic [MAX_PROCS-1:0] last;
  logic [MAX_PROCS-1:0] hit_vec;
  logic [MAX_PROCS-1:0] cur_zero_vec;
  logic          any_hit, cur_zero;
  logic [IW-1:0] hit_idx;
  ring_t         wrap;
  logic [PRIO_W-1:0] prio_clamp;
  logic [IW+2:0] cur_ext;

  // cell row
  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    assign last[i]         = (cnt_q == CW'(i + 1));
    assign hit_vec[i]      = stat[i].hit;
    assign cur_zero_vec[i] = stat[i].sel && stat[i].zero;
    if (i == 0) begin : g_head
      assign prev[i] = wrap;
    end else begin : g_body
      assign prev[i] = ring[i-1];
    end
    wrr_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .cnt_i  (cnt_q),
      .cur_i  (cur_q),
      .prev_i (prev[i]),
      .ring_o (ring[i]),
      .stat_o (stat[i])
    );
  end

  // ring wrap from the last filled cell back to cell zero, and token hit index
  always_comb begin
    wrap    = '0;
    hit_idx = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      if (last[i]) begin
        wrap.sel = wrap.sel | ring[i].sel;
        wrap.tok = wrap.tok | ring[i].tok;
      end
      if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  assign any_hit    = |hit_vec;
  assign cur_zero   = |cur_zero_vec;
  assign prio_clamp = (in_i.priority_req > PRIO_W'(MAX_PRIORITY)) ?
                      PRIO_W'(MAX_PRIORITY) : in_i.priority_req;

  // controller: decode, token search, response
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    cur_d     = cur_q;
    started_d = started_q;
    halted_d  = halted_q;
    rej_d     = rej_q;
    ctrl      = '0;
    ctrl.prio = prio_clamp;
    out_load  = 1'b0;
    in_i.ready = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rej_d   = 1'b0;
          state_d = ST_RESP;
          case (in_i.mode)
            MODE_CREATE: begin
              if (started_q || (cnt_q >= CW'(MAX_PROCS))) begin
                rej_d = 1'b1;
              end else begin
                ctrl.create = 1'b1;
                cnt_d       = cnt_q + 1'b1;
              end
            end
            MODE_TICK: begin
              if (cnt_q != '0) begin
                started_d = 1'b1;
                if (!halted_q && !in_i.system_busy) begin
                  if (!cur_zero) begin
                    ctrl.dec = 1'b1;
                  end else begin
                    ctrl.reload    = 1'b1;
                    ctrl.tok_start = 1'b1;
                    k_d            = CW'(1);
                    state_d        = ST_SCAN;
                  end
                end
              end
            end
            MODE_TERM: begin
              if ((cnt_q != '0) && !halted_q) ctrl.kill = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (any_hit) begin
          cur_d   = hit_idx;
          state_d = ST_RESP;
        end else if (k_q == cnt_q) begin
          halted_d = 1'b1;
          state_d  = ST_RESP;
        end else begin
          ctrl.tok_step = 1'b1;
          k_d           = k_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      k_q       <= '0;
      cur_q     <= '0;
      started_q <= 1'b0;
      halted_q  <= 1'b0;
      rej_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      cur_q     <= cur_d;
      started_q <= started_d;
      halted_q  <= halted_d;
      rej_q     <= rej_d;
    end
  end

  // output register
  assign cur_ext     = {3'b000, cur_q};
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cur_q  <= cur_ext[2:0];
      out_run_q  <= (cnt_q != '0) && !halted_q;
      out_halt_q <= halted_q;
      out_rej_q  <= rej_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.current_slot = out_cur_q;
  assign out_o.running      = out_run_q;
  assign out_o.halted       = out_halt_q;
  assign out_o.rejected     = out_rej_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the weighted round-robin scheduler
// Request beats are driven through the request channel. Each accepted beat
// updates a cycle-free model of the slot table, which queues the status beat
// it should produce. A separate process takes status beats with random
// stalls and compares them field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import wrr_pkg::*;

  localparam int NUM_SLOTS  = 8;
  localparam int PRIO_CAP   = 10;
  localparam int N_RANDOM   = 1850;
  localparam int CHUNK      = 100;
  localparam int HOLD_LONG  = 60;
  localparam int TAIL_WAIT  = 20;

  // Mode value with no meaning to the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] slot;
    logic       running;
    logic       halted;
    logic       rejected;
  } status_t;

  logic clk_i;
  logic rst_ni;

  wrr_in_if  req_bus ();
  wrr_out_if stat_bus ();

  weighted_round_robin_scheduler #(
    .MAX_PROCS    (NUM_SLOTS),
    .MAX_PRIORITY (PRIO_CAP)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (stat_bus)
  );

  // Slot table as the scheduler should hold it
  logic [3:0]  slot_prio   [NUM_SLOTS];
  logic [3:0]  slot_slices [NUM_SLOTS];
  logic        slot_live   [NUM_SLOTS];
  int unsigned n_slots;
  int unsigned cur_slot;
  bit          sched_started;
  bit          sched_halted;

  status_t expected_status_q [$];
  int      fail_count;
  int      src_gap_max;
  int      snk_gap_max;
  int      snk_hold;

  // --------------------------------------------------------------------------
  // Slot table update for one request, giving the status it should produce
  // --------------------------------------------------------------------------
  function automatic status_t predict_status(input logic [1:0] mode,
                                             input logic [3:0] prio,
                                             input logic       busy);
    status_t     st;
    int unsigned c;
    int unsigned probe;
    bit          found;
    logic [3:0]  clamped;
    st.rejected = 1'b0;
    case (mode)
      MODE_CREATE: begin
        if (sched_started || n_slots >= NUM_SLOTS) begin
          st.rejected = 1'b1;
        end else begin
          clamped = (prio > PRIO_CAP) ? 4'(PRIO_CAP) : prio;
          slot_prio[n_slots]   = clamped;
          slot_slices[n_slots] = clamped;
          slot_live[n_slots]   = 1'b1;
          n_slots++;
        end
      end
      MODE_TICK: begin
        if (n_slots != 0) begin
          sched_started = 1'b1;
          if (!sched_halted && !busy) begin
            c = cur_slot % n_slots;
            if (slot_slices[c] != 0) begin
              slot_slices[c] = slot_slices[c] - 4'd1;
            end else begin
              // reload, then hunt for the next live slot, own slot last
              slot_slices[c] = slot_prio[c];
              found = 1'b0;
              for (int unsigned k = 1; k <= n_slots && !found; k++) begin
                probe = (c + k) % n_slots;
                if (slot_live[probe]) begin
                  cur_slot = probe;
                  found    = 1'b1;
                end
              end
              if (!found) sched_halted = 1'b1;
            end
          end
        end
      end
      MODE_TERM: begin
        if (n_slots != 0 && !sched_halted) slot_live[cur_slot % n_slots] = 1'b0;
      end
      default: ;
    endcase
    st.slot    = 3'(cur_slot);
    st.running = (n_slots != 0) && !sched_halted;
    st.halted  = sched_halted;
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: one beat with a random lead-in gap
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [1:0] mode, input logic [3:0] prio,
                          input logic busy);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(src_gap_max, 0);
    @(negedge clk_i);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.mode         <= mode;
    req_bus.priority_req <= prio;
    req_bus.system_busy  <= busy;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    expected_status_q.push_back(predict_status(mode, prio, busy));
  endtask

  task automatic send_tick(input logic busy);
    send_req(MODE_TICK, 4'($urandom_range(15, 0)), busy);
  endtask

  // Stop offering beats and let every outstanding status come back
  task automatic pause_until_drained();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    wait (expected_status_q.size() == 0);
  endtask

  // --------------------------------------------------------------------------
  // Status side: random stalls, long hold on request, field-by-field check
  // --------------------------------------------------------------------------
  initial begin : status_sink
    int      gap;
    status_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (snk_hold > 0) begin
        gap      = snk_hold;
        snk_hold = 0;
      end else begin
        gap = (snk_gap_max == 0) ? 0 : $urandom_range(snk_gap_max, 0);
      end
      @(negedge clk_i);
      if (gap > 0) begin
        stat_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      stat_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (stat_bus.valid !== 1'b1) @(posedge clk_i);
      if (expected_status_q.size() == 0) begin
        $error("status beat with none expected: slot %0d", stat_bus.current_slot);
        fail_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (stat_bus.current_slot !== want.slot) begin
          $error("current_slot: expected %0d, got %0d", want.slot, stat_bus.current_slot);
          fail_count++;
        end
        if (stat_bus.running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, stat_bus.running);
          fail_count++;
        end
        if (stat_bus.halted !== want.halted) begin
          $error("halted: expected %0d, got %0d", want.halted, stat_bus.halted);
          fail_count++;
        end
        if (stat_bus.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, stat_bus.rejected);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Nothing created yet: every request leaves the block idle
  task automatic test_empty_system();
    send_req(MODE_UNUSED, 4'd15, 1'b1);
    send_req(MODE_TICK, 4'd0, 1'b0);
    send_req(MODE_TICK, 4'd15, 1'b1);
    send_req(MODE_TERM, 4'd0, 1'b0);
  endtask

  // Fill the table with edge priorities, then one create too many
  task automatic test_fill_slots();
    send_req(MODE_CREATE, 4'd0, 1'b0);
    send_req(MODE_CREATE, 4'd15, 1'b1);
    send_req(MODE_CREATE, 4'(PRIO_CAP), 1'b0);
    send_req(MODE_CREATE, 4'(PRIO_CAP + 1), 1'b0);
    send_req(MODE_CREATE, 4'd1, 1'b0);
    repeat (NUM_SLOTS - 5) send_req(MODE_CREATE, 4'($urandom_range(15, 0)), 1'b0);
    send_req(MODE_CREATE, 4'd3, 1'b0);
  endtask

  // A busy first tick still starts the system and closes creation
  task automatic test_busy_first_tick();
    send_tick(1'b1);
    send_req(MODE_CREATE, 4'd2, 1'b0);
    send_req(MODE_UNUSED, 4'd0, 1'b0);
  endtask

  // Zero-priority slot hands over at once; a killed slot still spends slices
  task automatic test_killed_slot();
    send_tick(1'b0);
    send_req(MODE_TERM, 4'd0, 1'b0);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Status side stalls for a long stretch while requests keep coming
  task automatic test_backpressure();
    int saved;
    saved       = src_gap_max;
    src_gap_max = 0;
    snk_hold    = HOLD_LONG;
    repeat (8) send_tick(1'($urandom_range(3, 0) == 0));
    pause_until_drained();
    src_gap_max = saved;
  endtask

  // Long random schedule, mostly ticks, with rare kills and stray requests
  task automatic test_random_schedule();
    int          r;
    logic [1:0]  mode;
    for (int i = 0; i < N_RANDOM; i++) begin
      // stretches with and without idling on both sides
      if (i % CHUNK == 0) begin
        src_gap_max = ((i / CHUNK) % 3 == 0) ? 0 : 5;
        snk_gap_max = ((i / CHUNK) % 4 == 1) ? 0 : 5;
      end
      r = $urandom_range(999, 0);
      if (r < 4)       mode = MODE_TERM;
      else if (r < 60) mode = MODE_CREATE;
      else if (r < 80) mode = MODE_UNUSED;
      else             mode = MODE_TICK;
      send_req(mode, 4'($urandom_range(15, 0)), 1'($urandom_range(3, 0) == 0));
    end
  endtask

  // Kill slots until none is left, then poke the halted block
  task automatic test_halt();
    int rounds;
    rounds = 0;
    while (!sched_halted && rounds < NUM_SLOTS + 2) begin
      send_req(MODE_TERM, 4'($urandom_range(15, 0)), 1'b0);
      repeat (PRIO_CAP + 2) send_tick(1'b0);
      rounds++;
    end
    send_tick(1'b0);
    send_tick(1'b1);
    send_req(MODE_TERM, 4'd0, 1'b0);
    send_req(MODE_CREATE, 4'd5, 1'b0);
    send_req(MODE_UNUSED, 4'd15, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and test sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_prio[i]   = '0;
      slot_slices[i] = '0;
      slot_live[i]   = 1'b0;
    end
    n_slots       = 0;
    cur_slot      = 0;
    sched_started = 1'b0;
    sched_halted  = 1'b0;
    fail_count    = 0;
    src_gap_max   = 5;
    snk_gap_max   = 5;
    snk_hold      = 0;

    req_bus.valid        = 1'b0;
    req_bus.mode         = MODE_TICK;
    req_bus.priority_req = '0;
    req_bus.system_busy  = 1'b0;
    stat_bus.ready       = 1'b0;
    rst_ni               = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_system();
    test_fill_slots();
    test_busy_first_tick();
    test_killed_slot();
    test_backpressure();
    test_random_schedule();
    test_halt();

    pause_until_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wrr_pkg.sv
hw/rtl/wrr_in_if.sv
hw/rtl/wrr_out_if.sv
hw/rtl/wrr_cell.sv
hw/rtl/weighted_round_robin_scheduler.sv
verif/testbench.sv
